>>> design/bstm_pkg.sv
package bstm_pkg;

	localparam int unsigned DW   = 16;
	localparam int unsigned NW   = 15;
	localparam int unsigned CMPW = DW + 2;
	localparam int unsigned IDXW = 3;
	localparam int unsigned CNTW = $clog2(DW);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// how the bend of the current item is formed
	typedef enum logic [1:0] {
		PATH_ZERO,
		PATH_HOLD,
		PATH_SUB,
		PATH_ADD
	} path_t;

	localparam logic [IDXW-1:0] REG_IDLE_LEVEL  = 3'd0;
	localparam logic [IDXW-1:0] REG_INPUT_TOP   = 3'd1;
	localparam logic [IDXW-1:0] REG_INPUT_BOT   = 3'd2;
	localparam logic [IDXW-1:0] REG_NOISE       = 3'd3;
	localparam logic [IDXW-1:0] REG_HYST        = 3'd4;
	localparam logic [IDXW-1:0] REG_OUT_ZERO    = 3'd5;
	localparam logic [IDXW-1:0] REG_OUT_SPAN    = 3'd6;

	localparam logic [DW-1:0] RST_IDLE_LEVEL = 16'd32768;
	localparam logic [DW-1:0] RST_INPUT_TOP  = 16'd65535;
	localparam logic [DW-1:0] RST_INPUT_BOT  = 16'd0;
	localparam logic [NW-1:0] RST_NOISE      = 15'd1000;
	localparam logic [NW-1:0] RST_HYST       = 15'd200;
	localparam logic [DW-1:0] RST_OUT_ZERO   = 16'd32768;
	localparam logic [DW-1:0] RST_OUT_SPAN   = 16'd32767;

endpackage

>>> design/bend_sensor_tristate_mapper.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------
// in       | in_valid/in_stall  | sample[15:0]
// out      | out_valid/out_stall| mode[1:0], bend[15:0], mode_changed
// cfg      | cfg_we             | cfg_index[2:0], cfg_data[15:0]
//
// A scaled item runs 16 shift-add multiply steps and then 16 restoring divide steps
// on one shared 32-bit register between its accept and the hand-off of its result;
// in_stall holds off the next item until then.
// Items in idle mode or whose sample holds the last bend go straight to the done state.
// Reset is asynchronous, active low; control and config registers take reset values.
// A result waits in the output register under out_stall; a new item is taken meanwhile.
module bend_sensor_tristate_mapper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bstm_pkg::IDXW-1:0]    cfg_index,
	input  logic [bstm_pkg::DW-1:0]      cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bstm_pkg::DW-1:0]      sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   mode,
	output logic [bstm_pkg::DW-1:0]      bend,
	output logic                         mode_changed
);

	localparam int unsigned DW   = bstm_pkg::DW;
	localparam int unsigned NW   = bstm_pkg::NW;
	localparam int unsigned CMPW = bstm_pkg::CMPW;
	localparam int unsigned CNTW = bstm_pkg::CNTW;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

	// configuration
	logic [DW-1:0] idle_q, top_q, bot_q, zero_q, span_q;
	logic [NW-1:0] noise_q, hyst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= bstm_pkg::RST_IDLE_LEVEL;
			top_q   <= bstm_pkg::RST_INPUT_TOP;
			bot_q   <= bstm_pkg::RST_INPUT_BOT;
			noise_q <= bstm_pkg::RST_NOISE;
			hyst_q  <= bstm_pkg::RST_HYST;
			zero_q  <= bstm_pkg::RST_OUT_ZERO;
			span_q  <= bstm_pkg::RST_OUT_SPAN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bstm_pkg::REG_IDLE_LEVEL: idle_q  <= cfg_data;
				bstm_pkg::REG_INPUT_TOP:  top_q   <= cfg_data;
				bstm_pkg::REG_INPUT_BOT:  bot_q   <= cfg_data;
				bstm_pkg::REG_NOISE:      noise_q <= cfg_data[NW-1:0];
				bstm_pkg::REG_HYST:       hyst_q  <= cfg_data[NW-1:0];
				bstm_pkg::REG_OUT_ZERO:   zero_q  <= cfg_data;
				bstm_pkg::REG_OUT_SPAN:   span_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and state registers
	bstm_pkg::state_t state_q, state_d;
	bstm_pkg::mode_t  bend_mode_q, nxt_mode;
	bstm_pkg::path_t  path_q, path_d;
	logic [DW-1:0]    last_bend_q;
	logic [CNTW-1:0]  cnt_q;
	logic             chg_q;

	// datapath
	logic [2*DW-1:0]  p_q;
	logic [DW-1:0]    den_q;

	logic             accept, out_free;
	logic             out_valid_q, mode_chg_out_q;
	logic [1:0]       mode_out_q;
	logic [DW-1:0]    bend_out_q;

	// signed thresholds, two bits wider than the sample so none wraps
	logic signed [CMPW-1:0] s_x, i_x, n_x, h_x, up_th, dn_th, up_ret, dn_ret;

	assign s_x    = $signed({2'b00, sample});
	assign i_x    = $signed({2'b00, idle_q});
	assign n_x    = $signed({3'b000, noise_q});
	assign h_x    = $signed({3'b000, hyst_q});
	assign up_th  = i_x + n_x;
	assign dn_th  = i_x - n_x;
	assign up_ret = up_th - h_x;
	assign dn_ret = dn_th + h_x;

	always_comb begin
		nxt_mode = bend_mode_q;
		unique case (bend_mode_q)
			bstm_pkg::MODE_IDLE: begin
				if (s_x > up_th)
					nxt_mode = bstm_pkg::MODE_UP;
				else if (s_x < dn_th)
					nxt_mode = bstm_pkg::MODE_DOWN;
				else
					nxt_mode = bstm_pkg::MODE_IDLE;
			end
			bstm_pkg::MODE_UP: begin
				nxt_mode = (s_x < up_ret) ? bstm_pkg::MODE_IDLE : bstm_pkg::MODE_UP;
			end
			default: begin
				nxt_mode = (s_x > dn_ret) ? bstm_pkg::MODE_IDLE : bstm_pkg::MODE_DOWN;
			end
		endcase
	end

	// scaling range is picked by the sample alone
	logic          in_up, in_dn;
	logic [DW-1:0] dist_d, den_d;

	assign in_up  = (sample > idle_q) && (sample < top_q);
	assign in_dn  = (sample < idle_q) && (sample > bot_q);
	assign dist_d = in_up ? (sample - idle_q) : (idle_q - sample);
	assign den_d  = in_up ? (top_q - idle_q) : (idle_q - bot_q);

	always_comb begin
		if (nxt_mode == bstm_pkg::MODE_IDLE)
			path_d = bstm_pkg::PATH_ZERO;
		else if (in_up)
			path_d = bstm_pkg::PATH_SUB;
		else if (in_dn)
			path_d = bstm_pkg::PATH_ADD;
		else
			path_d = bstm_pkg::PATH_HOLD;
	end

	assign in_stall = (state_q != bstm_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bstm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bstm_pkg::ST_IDLE: begin
				if (accept) begin
					if (path_d == bstm_pkg::PATH_SUB || path_d == bstm_pkg::PATH_ADD)
						state_d = bstm_pkg::ST_MUL;
					else
						state_d = bstm_pkg::ST_DONE;
				end
			end
			bstm_pkg::ST_MUL: begin
				if (cnt_q == '0)
					state_d = bstm_pkg::ST_DIV;
			end
			bstm_pkg::ST_DIV: begin
				if (cnt_q == '0)
					state_d = bstm_pkg::ST_DONE;
			end
			bstm_pkg::ST_DONE: begin
				if (out_free)
					state_d = bstm_pkg::ST_IDLE;
			end
			default: state_d = bstm_pkg::ST_IDLE;
		endcase
	end

	// one multiply bit per cycle: add span into the high half, shift right
	logic [DW:0]   mul_sum;
	// one quotient bit per cycle; the high half stays below the divisor
	logic [DW:0]   rem_sh;
	logic [DW+1:0] div_diff;
	logic          div_take;
	logic [DW-1:0] rem_nxt, quot, result;

	assign mul_sum  = {1'b0, p_q[2*DW-1:DW]} + (p_q[0] ? {1'b0, span_q} : {(DW+1){1'b0}});
	assign rem_sh   = {p_q[2*DW-1:DW], p_q[DW-1]};
	assign div_diff = {1'b0, rem_sh} - {2'b00, den_q};
	assign div_take = !div_diff[DW+1];
	assign rem_nxt  = div_take ? div_diff[DW-1:0] : rem_sh[DW-1:0];
	assign quot     = p_q[DW-1:0];

	always_comb begin
		unique case (path_q)
			bstm_pkg::PATH_ZERO: result = zero_q;
			bstm_pkg::PATH_HOLD: result = last_bend_q;
			bstm_pkg::PATH_SUB:  result = zero_q - quot;
			default:             result = zero_q + quot;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= {{DW{1'b0}}, dist_d};
			den_q  <= den_d;
			path_q <= path_d;
		end else if (state_q == bstm_pkg::ST_MUL) begin
			p_q <= {mul_sum, p_q[DW-1:1]};
		end else if (state_q == bstm_pkg::ST_DIV) begin
			p_q <= {rem_nxt, p_q[DW-2:0], div_take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			chg_q       <= 1'b0;
			bend_mode_q <= bstm_pkg::MODE_IDLE;
			last_bend_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= CNT_LAST;
				chg_q       <= (nxt_mode != bend_mode_q);
				bend_mode_q <= nxt_mode;
			end else if (state_q == bstm_pkg::ST_MUL || state_q == bstm_pkg::ST_DIV) begin
				cnt_q <= (cnt_q == '0) ? CNT_LAST : cnt_q - 1'b1;
			end

			if (state_q == bstm_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				last_bend_q <= result;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bstm_pkg::ST_DONE && out_free) begin
			mode_out_q     <= bend_mode_q;
			bend_out_q     <= result;
			mode_chg_out_q <= chg_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mode         = mode_out_q;
	assign bend         = bend_out_q;
	assign mode_changed = mode_chg_out_q;

endmodule

>>> design/bstm_checker.sv
module bstm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic [bstm_pkg::IDXW-1:0]  cfg_index,
	input logic [bstm_pkg::DW-1:0]    cfg_data,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 mode,
	input logic [bstm_pkg::DW-1:0]    bend,
	input logic                       mode_changed
);

	logic [bstm_pkg::DW-1:0] zero_q;
	logic [1:0]              prev_mode_q;

	// shadow of the output zero code and of the last delivered mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q      <= bstm_pkg::RST_OUT_ZERO;
			prev_mode_q <= bstm_pkg::MODE_IDLE;
		end else begin
			if (cfg_we && cfg_index == bstm_pkg::REG_OUT_ZERO)
				zero_q <= cfg_data;
			if (out_valid && !out_stall)
				prev_mode_q <= mode;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({mode, bend, mode_changed}))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while first in flight");

	a_idle_bend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == bstm_pkg::MODE_IDLE |-> bend == zero_q)
		else $error("idle mode bend is not the zero code");

	a_change_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mode_changed == (mode != prev_mode_q))
		else $error("mode_changed disagrees with delivered modes");

endmodule

bind bend_sensor_tristate_mapper bstm_checker u_bstm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mode         (mode),
	.bend         (bend),
	.mode_changed (mode_changed)
);

>>> dv/tb_bend_sensor_tristate_mapper.sv
module tb_bend_sensor_tristate_mapper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bstm_pkg::IDXW-1:0] REG_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		bstm_pkg::mode_t mode;
		logic [15:0]     bend;
		logic            changed;
	} bend_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [bstm_pkg::IDXW-1:0]   cfg_index = '0;
	logic [bstm_pkg::DW-1:0]     cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [bstm_pkg::DW-1:0]     sample = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  mode;
	logic [bstm_pkg::DW-1:0]     bend;
	logic                        mode_changed;

	// predictor copy of the register file and block state
	logic [15:0]     cfg_idle  = bstm_pkg::RST_IDLE_LEVEL;
	logic [15:0]     cfg_top   = bstm_pkg::RST_INPUT_TOP;
	logic [15:0]     cfg_bot   = bstm_pkg::RST_INPUT_BOT;
	logic [14:0]     cfg_noise = bstm_pkg::RST_NOISE;
	logic [14:0]     cfg_hyst  = bstm_pkg::RST_HYST;
	logic [15:0]     cfg_zero  = bstm_pkg::RST_OUT_ZERO;
	logic [15:0]     cfg_span  = bstm_pkg::RST_OUT_SPAN;
	bstm_pkg::mode_t cur_mode  = bstm_pkg::MODE_IDLE;
	logic [15:0]     held_bend = '0;

	bend_result_t bend_q[$];
	int errors = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	bend_sensor_tristate_mapper u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mode         (mode),
		.bend         (bend),
		.mode_changed (mode_changed)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp16(input int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	function automatic void note_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	// mode update, then bend; thresholds compared as signed ints so nothing wraps
	function automatic void predict_bend(input logic [15:0] s);
		int si, lvl, nm, hb, tp, bt;
		longint q;
		bstm_pkg::mode_t nxt;
		logic [15:0] b;
		bend_result_t r;
		si  = int'(s);
		lvl = int'(cfg_idle);
		nm  = int'(cfg_noise);
		hb  = int'(cfg_hyst);
		tp  = int'(cfg_top);
		bt  = int'(cfg_bot);
		case (cur_mode)
			bstm_pkg::MODE_IDLE: begin
				if (si > lvl + nm)
					nxt = bstm_pkg::MODE_UP;
				else if (si < lvl - nm)
					nxt = bstm_pkg::MODE_DOWN;
				else
					nxt = bstm_pkg::MODE_IDLE;
			end
			bstm_pkg::MODE_UP:
				nxt = (si < lvl + nm - hb) ? bstm_pkg::MODE_IDLE : bstm_pkg::MODE_UP;
			default:
				nxt = (si > lvl - nm + hb) ? bstm_pkg::MODE_IDLE : bstm_pkg::MODE_DOWN;
		endcase
		if (nxt == bstm_pkg::MODE_IDLE) begin
			b = cfg_zero;
		end else if (si > lvl && si < tp) begin
			q = longint'(cfg_span) * longint'(si - lvl) / longint'(tp - lvl);
			b = cfg_zero - 16'(q);
		end else if (si < lvl && si > bt) begin
			q = longint'(cfg_span) * longint'(lvl - si) / longint'(lvl - bt);
			b = cfg_zero + 16'(q);
		end else begin
			b = held_bend;
		end
		r.mode    = nxt;
		r.bend    = b;
		r.changed = (nxt != cur_mode);
		bend_q.push_back(r);
		cur_mode  = nxt;
		held_bend = b;
	endfunction

	task automatic send_sample(input logic [15:0] s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do
			@(posedge clk);
		while (in_stall);
		predict_bend(s);
		items_sent++;
	endtask

	// drop valid and let the block drain before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bend_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bstm_pkg::IDXW-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bstm_pkg::REG_IDLE_LEVEL: cfg_idle  = data;
			bstm_pkg::REG_INPUT_TOP:  cfg_top   = data;
			bstm_pkg::REG_INPUT_BOT:  cfg_bot   = data;
			bstm_pkg::REG_NOISE:      cfg_noise = data[14:0];
			bstm_pkg::REG_HYST:       cfg_hyst  = data[14:0];
			bstm_pkg::REG_OUT_ZERO:   cfg_zero  = data;
			bstm_pkg::REG_OUT_SPAN:   cfg_span  = data;
			default: ;
		endcase
	endtask

	task automatic write_random_config();
		int lvl, tp, bt, nm, hb;
		lvl = $urandom_range(4000, 61000);
		if ($urandom_range(0, 7) == 0) begin
			tp = $urandom_range(0, 65535);
			bt = $urandom_range(0, 65535);
		end else begin
			tp = $urandom_range(lvl + 1, 65535);
			bt = $urandom_range(0, lvl - 1);
		end
		nm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
		hb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, nm);
		write_reg(bstm_pkg::REG_IDLE_LEVEL, 16'(lvl));
		write_reg(bstm_pkg::REG_INPUT_TOP, 16'(tp));
		write_reg(bstm_pkg::REG_INPUT_BOT, 16'(bt));
		// upper data bit is outside the 15-bit registers and must be dropped
		write_reg(bstm_pkg::REG_NOISE, {1'($urandom_range(0, 1)), 15'(nm)});
		write_reg(bstm_pkg::REG_HYST, {1'($urandom_range(0, 1)), 15'(hb)});
		write_reg(bstm_pkg::REG_OUT_ZERO, 16'($urandom_range(0, 65535)));
		write_reg(bstm_pkg::REG_OUT_SPAN, 16'($urandom_range(0, 65535)));
	endtask

	// ramp away from idle to a peak and back, with jitter and the odd exact edge value
	task automatic send_gesture();
		int lvl, peak, back, n, k, s;
		bit up, broken;
		lvl    = int'(cfg_idle);
		up     = $urandom_range(0, 1);
		broken = ($urandom_range(0, 4) == 0);
		n      = $urandom_range(3, 10);
		peak   = up ? $urandom_range(lvl, 65535) : $urandom_range(0, lvl);
		back   = broken ? (up ? $urandom_range(0, lvl) : $urandom_range(lvl, 65535)) : lvl;
		for (k = 1; k <= 2 * n; k++) begin
			if (k <= n)
				s = lvl + (peak - lvl) * k / n;
			else
				s = peak + (back - peak) * (k - n) / n;
			s = clamp16(s + $urandom_range(0, 128) - 64);
			case ($urandom_range(0, 15))
				0: s = lvl;
				1: s = int'(cfg_top);
				2: s = int'(cfg_bot);
				default: ;
			endcase
			send_sample(16'(s));
		end
		repeat ($urandom_range(1, 3))
			send_sample(16'(clamp16(lvl + $urandom_range(0, 2 * cfg_noise) - cfg_noise)));
	endtask

	task automatic test_reset_defaults();
		send_sample(16'd65535);  // leaves idle at the top: holds the reset bend
		send_sample(16'd49152);
		send_sample(16'd32768);
		send_sample(16'd0);      // down at the bottom edge: holds
		send_sample(16'd1);
		send_sample(16'd32000);
		send_sample(16'd32768);
		send_sample(16'd33769);
		send_sample(16'd32768);
		settle();
	endtask

	task automatic test_register_extremes();
		write_reg(bstm_pkg::REG_IDLE_LEVEL, 16'd0);
		write_reg(bstm_pkg::REG_INPUT_TOP, 16'hFFFF);
		write_reg(bstm_pkg::REG_INPUT_BOT, 16'd0);
		write_reg(bstm_pkg::REG_NOISE, 16'd0);
		write_reg(bstm_pkg::REG_HYST, 16'd0);
		write_reg(bstm_pkg::REG_OUT_ZERO, 16'd0);
		write_reg(bstm_pkg::REG_OUT_SPAN, 16'hFFFF);
		send_sample(16'd1);      // zero minus a quotient of one wraps
		send_sample(16'd0);      // at idle while up: holds
		send_sample(16'hFFFF);
		send_sample(16'hFFFE);
		settle();

		write_reg(bstm_pkg::REG_IDLE_LEVEL, 16'hFFFF);
		write_reg(bstm_pkg::REG_NOISE, 16'hFFFF);
		write_reg(bstm_pkg::REG_HYST, 16'hFFFF);
		send_sample(16'd0);
		send_sample(16'd32767);
		send_sample(16'hFFFF);
		settle();

		// hysteresis larger than the margin: return threshold falls below idle
		write_reg(bstm_pkg::REG_IDLE_LEVEL, 16'd32768);
		write_reg(bstm_pkg::REG_NOISE, 16'd100);
		write_reg(bstm_pkg::REG_HYST, 16'h7FFF);
		write_reg(bstm_pkg::REG_OUT_ZERO, 16'hFFFF);
		send_sample(16'd40000);
		send_sample(16'd200);    // still up, but scaled on the low side
		send_sample(16'd100);
		settle();

		write_reg(REG_UNUSED, 16'h1234);
		write_reg(bstm_pkg::REG_OUT_SPAN, 16'd0);
		send_sample(16'd20000);
		send_sample(16'd20000);
		settle();
	endtask

	task automatic test_random_gestures();
		int phase, goal, r;
		for (phase = 0; phase < 8; phase++) begin
			write_random_config();
			quiet = (phase == 3);
			goal = items_sent + 160;
			while (items_sent < goal) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					send_gesture();
				else if (r < 9)
					send_sample(16'($urandom_range(0, 65535)));
				else
					send_sample(16'(clamp16(int'(cfg_idle) + cfg_noise
						- cfg_hyst + $urandom_range(0, 4) - 2)));
			end
			settle();
			quiet = 1'b0;
		end
	endtask

	task automatic test_output_backpressure();
		int k;
		write_random_config();
		quiet = 1'b1;
		hold_req = 1'b1;
		wait (!hold_req);
		quiet = 1'b0;
		for (k = 0; k < 50; k++)
			send_sample(16'($urandom_range(0, 65535)));
		settle();
	endtask

	// receiver stall: runs of stall and no-stall, plus one long forced hold
	initial begin : stall_gen
		int len;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				len = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				len = quiet ? 1 : $urandom_range(1, 6);
			end else begin
				out_stall <= 1'b1;
				len = 1 + pick_gap();
			end
			repeat (len - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		bend_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bend_q.size() == 0) begin
				note_mismatch($sformatf("unexpected item mode=%0d bend=%0d changed=%0b",
					mode, bend, mode_changed));
			end else begin
				want = bend_q.pop_front();
				if (mode !== 2'(want.mode))
					note_mismatch($sformatf("mode exp %0d got %0d", want.mode, mode));
				if (bend !== want.bend)
					note_mismatch($sformatf("bend exp %0d got %0d", want.bend, bend));
				if (mode_changed !== want.changed)
					note_mismatch($sformatf("mode_changed exp %0b got %0b",
						want.changed, mode_changed));
			end
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_gestures();
		test_output_backpressure();
		settle();
		if (errors == 0 && bend_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> bend_sensor_tristate_mapper.f
design/bstm_pkg.sv
design/bend_sensor_tristate_mapper.sv
design/bstm_checker.sv
dv/tb_bend_sensor_tristate_mapper.sv
